/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the top design file (clock and reset named as usual).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* design/jsih_pkg.sv */
// ----------------------------------------------------------------------------
// jsih_pkg
// Types, widths and constants of the joint setpoint integrator.
// ----------------------------------------------------------------------------
package jsih_pkg;

   localparam int POS_W      = 24;
   localparam int GRIP_W     = 17;
   localparam int TP_W       = 16;
   localparam int MR_W       = 23;
   localparam int DB_W       = 16;
   localparam int FRAC_BITS  = 16;
   localparam int NFIELD     = 6;
   localparam int NUM_JOINTS_DEF = 6;
   localparam int MAX_JOINTS = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 23;

   localparam logic [GRIP_W-1:0] GRIP_ONE   = GRIP_W'(1 << FRAC_BITS);
   localparam logic [GRIP_W-1:0] GRIP_RESET = GRIP_W'(1 << (FRAC_BITS - 1));

   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND = 2'd2;

   localparam logic [TP_W-1:0] PERIOD_RESET   = 16'd1311;
   localparam logic [MR_W-1:0] MAX_RATE_RESET = 23'd32768;
   localparam logic [DB_W-1:0] DEADBAND_RESET = 16'd66;

   // dividend of the landing-rate division: |d| (25 bits) << 16, plus half
   localparam int DVD_W     = 42;
   localparam int DIV_STEPS = DVD_W;
   localparam int DCNT_W    = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {ST_IDLE, ST_START, ST_BUSY} state_type;
   typedef enum logic [2:0] {LS_IDLE, LS_DIV, LS_SAT, LS_MUL, LS_ADD} lane_state_type;

   typedef struct packed {
      logic [TP_W-1:0] sample_period;
      logic [MR_W-1:0] max_rate;
      logic [DB_W-1:0] deadband;
   } cfg_type;

   typedef struct packed {
      logic                    kind;
      logic                    rate_load;
      logic                    home;
      logic                    zero;
      logic                    mask_bit;
      logic signed [POS_W-1:0] value;
   } lane_cmd_type;

   // home targets, 20 fraction bits, rounded half away from zero to FRAC_BITS
   function automatic logic signed [POS_W-1:0] home_target(input int j);
      longint c;
      longint m;
      int     sh;
      sh = 20 - FRAC_BITS;
      case (j)
         1:       c = 457527;
         2:       c = 1555594;
         4:       c = -549033;
         default: c = 0;
      endcase
      m = (c < 0) ? -c : c;
      if (sh > 0) m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
      return POS_W'((c < 0) ? -m : m);
   endfunction

endpackage

/* design/jsih_ifs.sv */
// ----------------------------------------------------------------------------
// jsih_ifs
// Request and response channel interfaces (valid/ready).
// ----------------------------------------------------------------------------
interface jsih_req_if import jsih_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic                    rate_load;
   logic signed [POS_W-1:0] value_0;
   logic signed [POS_W-1:0] value_1;
   logic signed [POS_W-1:0] value_2;
   logic signed [POS_W-1:0] value_3;
   logic signed [POS_W-1:0] value_4;
   logic signed [POS_W-1:0] value_5;
   logic signed [POS_W-1:0] gripper_rate;
   logic                    home_request;
   logic                    zero_request;
   logic [NFIELD-1:0]       joint_zero_mask;

   modport source (output valid, kind, rate_load, value_0, value_1, value_2, value_3,
                   value_4, value_5, gripper_rate, home_request, zero_request,
                   joint_zero_mask, input ready);
   modport sink   (input valid, kind, rate_load, value_0, value_1, value_2, value_3,
                   value_4, value_5, gripper_rate, home_request, zero_request,
                   joint_zero_mask, output ready);
endinterface

interface jsih_rsp_if import jsih_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] pos_0;
   logic signed [POS_W-1:0] pos_1;
   logic signed [POS_W-1:0] pos_2;
   logic signed [POS_W-1:0] pos_3;
   logic signed [POS_W-1:0] pos_4;
   logic signed [POS_W-1:0] pos_5;
   logic [GRIP_W-1:0]       gripper_pos;

   modport source (output valid, pos_0, pos_1, pos_2, pos_3, pos_4, pos_5, gripper_pos,
                   input ready);
   modport sink   (input valid, pos_0, pos_1, pos_2, pos_3, pos_4, pos_5, gripper_pos,
                   output ready);
endinterface

/* design/jsih_lane.sv */
// ----------------------------------------------------------------------------
// jsih_lane
// One joint: mode select, approach rate with serial landing divider, integrate.
// ----------------------------------------------------------------------------
module jsih_lane import jsih_pkg::*; #(
   parameter int JOINT = 0,
   parameter bit LAST  = 1'b0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  lane_cmd_type            cmd,
   input  cfg_type                 cfg,
   input  logic [POS_W-1:0]        step,
   input  logic signed [POS_W-1:0] next_pos,
   output logic signed [POS_W-1:0] pos,
   output logic                    busy
);

   localparam int EW = POS_W + 3;
   localparam int PW = POS_W + TP_W + 1;
   localparam logic signed [POS_W-1:0] HOME_TGT  = home_target(JOINT);
   localparam logic signed [POS_W-1:0] NEXT_TGT  = home_target(JOINT + 1);
   localparam logic [DVD_W-1:0] POS_LIM = DVD_W'(1 << (POS_W - 1));

   lane_state_type          state_ff, state_in;
   logic signed [POS_W-1:0] pos_ff, pos_in;
   logic signed [POS_W-1:0] rate_ff, rate_in;
   logic [TP_W-1:0]         rem_ff, rem_in;
   logic [DVD_W-1:0]        quo_ff, quo_in;
   logic                    neg_ff, neg_in;
   logic [DCNT_W-1:0]       cnt_ff, cnt_in;
   logic signed [PW-1:0]    prod_ff, prod_in;

   logic signed [EW-1:0] q, tgt, ntg, e, dbv, mrv, stepv, d, mag;
   logic                 near, gate, approach, need_div;
   logic signed [POS_W-1:0] fixed_rate, sel_rate;
   logic [TP_W-1:0]      divisor;
   logic [DVD_W-1:0]     dividend;
   logic [TP_W:0]        shifted;
   logic                 ge;
   logic signed [PW:0]   rounded, sum;

   always_comb begin
      q     = EW'(pos_ff);
      tgt   = (cmd.mask_bit || cmd.zero) ? '0 : EW'(HOME_TGT);
      ntg   = cmd.zero ? '0 : EW'(NEXT_TGT);
      e     = EW'(next_pos) - ntg;
      dbv   = EW'(cfg.deadband);
      mrv   = EW'(cfg.max_rate);
      stepv = EW'(step);
      near  = (e <= dbv) && (e >= -dbv);
      gate  = cmd.mask_bit || LAST || near;
      approach = cmd.mask_bit || cmd.zero || cmd.home;
      need_div   = 1'b0;
      fixed_rate = '0;
      if (q < tgt - dbv) begin
         if (q + stepv <= tgt) fixed_rate = POS_W'(mrv);
         else need_div = 1'b1;
      end else if (q > tgt + dbv) begin
         if (q - stepv >= tgt) fixed_rate = POS_W'(-mrv);
         else need_div = 1'b1;
      end
      d   = tgt - q;
      mag = (d < 0) ? -d : d;
      divisor  = (cfg.sample_period == '0) ? TP_W'(1) : cfg.sample_period;
      dividend = (DVD_W'(mag[POS_W:0]) << TP_W) + DVD_W'(divisor >> 1);
      if (!approach) sel_rate = cmd.rate_load ? cmd.value : rate_ff;
      else if (gate) sel_rate = fixed_rate;
      else           sel_rate = '0;
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      ge      = shifted >= {1'b0, divisor};
      rounded = (PW + 1)'(prod_ff) + (PW + 1)'(1 << (TP_W - 1));
      sum     = (PW + 1)'(pos_ff) + (rounded >>> TP_W);
   end

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      rate_in  = rate_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      case (state_ff)
         LS_IDLE: begin
            if (start) begin
               if (cmd.kind) begin
                  pos_in = cmd.value;
               end else if (approach && gate && need_div) begin
                  rem_in   = '0;
                  quo_in   = dividend;
                  neg_in   = d < 0;
                  cnt_in   = '0;
                  state_in = LS_DIV;
               end else begin
                  rate_in  = sel_rate;
                  state_in = LS_MUL;
               end
            end
         end
         LS_DIV: begin
            rem_in = ge ? TP_W'(shifted - {1'b0, divisor}) : TP_W'(shifted);
            quo_in = {quo_ff[DVD_W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DCNT_W'(DIV_STEPS - 1)) state_in = LS_SAT;
         end
         LS_SAT: begin
            if (neg_ff) begin
               rate_in = (quo_ff > POS_LIM) ? POS_W'(POS_LIM) : POS_W'(-quo_ff);
            end else begin
               rate_in = (quo_ff >= POS_LIM) ? POS_W'(POS_LIM - 1'b1) : POS_W'(quo_ff);
            end
            state_in = LS_MUL;
         end
         LS_MUL: begin
            prod_in  = PW'(rate_ff * $signed({1'b0, cfg.sample_period}));
            state_in = LS_ADD;
         end
         LS_ADD: begin
            if (sum > (PW + 1)'((1 << (POS_W - 1)) - 1))  pos_in = {1'b0, {(POS_W-1){1'b1}}};
            else if (sum < -(PW + 1)'(1 << (POS_W - 1))) pos_in = {1'b1, {(POS_W-1){1'b0}}};
            else pos_in = POS_W'(sum);
            state_in = LS_IDLE;
         end
         default: state_in = LS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LS_IDLE;
         pos_ff   <= '0;
         rate_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         rate_ff  <= rate_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
   end

   assign pos  = pos_ff;
   assign busy = state_ff != LS_IDLE;

endmodule

/* design/jsih_merge.sv */
// ----------------------------------------------------------------------------
// jsih_merge
// Gathers lane positions, updates the gripper, holds the response register.
// ----------------------------------------------------------------------------
module jsih_merge import jsih_pkg::*; #(
   parameter int NUM_JOINTS = NUM_JOINTS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    kind,
   input  logic signed [POS_W-1:0] gripper_rate,
   input  logic [TP_W-1:0]         sample_period,
   input  logic                    finish,
   input  logic signed [POS_W-1:0] lane_pos [NUM_JOINTS],
   output logic                    out_free,
   jsih_rsp_if.source              rsp_bus
);

   localparam int PW = POS_W + TP_W + 1;

   logic [GRIP_W-1:0]       grip_ff, grip_in;
   logic signed [PW-1:0]    gprod_ff;
   logic                    kind_ff;
   logic                    valid_ff;
   logic signed [POS_W-1:0] opos_ff [NFIELD];
   logic signed [POS_W-1:0] gather [NFIELD];
   logic [GRIP_W-1:0]       ogrip_ff;
   logic signed [PW:0]      rounded, g;

   for (genvar j = 0; j < NFIELD; j++) begin : g_gather
      if (j < NUM_JOINTS) begin : g_on
         assign gather[j] = lane_pos[j];
      end else begin : g_off
         assign gather[j] = '0;
      end
   end

   always_comb begin
      rounded = (PW + 1)'(gprod_ff) + (PW + 1)'(1 << (TP_W - 1));
      // signed sum, so that a negative step shifts arithmetically
      g       = $signed((PW + 1)'(grip_ff)) + (rounded >>> TP_W);
      if (kind_ff)                                grip_in = grip_ff;
      else if (g <= 0)                            grip_in = '0;
      else if (g >= $signed((PW + 1)'(GRIP_ONE))) grip_in = GRIP_ONE;
      else                                        grip_in = GRIP_W'(g);
   end

   assign out_free = !valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         grip_ff  <= GRIP_RESET;
         valid_ff <= 1'b0;
      end else begin
         if (finish) grip_ff <= grip_in;
         if (finish) valid_ff <= 1'b1;
         else if (rsp_bus.ready) valid_ff <= 1'b0;
      end
      if (start) begin
         gprod_ff <= PW'(gripper_rate * $signed({1'b0, sample_period}));
         kind_ff  <= kind;
      end
      if (finish) begin
         opos_ff  <= gather;
         ogrip_ff <= grip_in;
      end
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.pos_0       = opos_ff[0];
   assign rsp_bus.pos_1       = opos_ff[1];
   assign rsp_bus.pos_2       = opos_ff[2];
   assign rsp_bus.pos_3       = opos_ff[3];
   assign rsp_bus.pos_4       = opos_ff[4];
   assign rsp_bus.pos_5       = opos_ff[5];
   assign rsp_bus.gripper_pos = ogrip_ff;

endmodule

/* design/joint_setpoint_integrator_homing.sv */
// ----------------------------------------------------------------------------
// joint_setpoint_integrator_homing
// Tick-driven joint and gripper setpoint generator with sequential homing.
// ----------------------------------------------------------------------------
// One request transfer gives one response transfer. A tick latches the
// request, starts the lanes, runs the one-bit-per-cycle landing divider
// that every joint lane carries, then saturates, multiplies by the tick
// period and adds. The divider runs only on a joint's landing tick; other
// ticks skip it, and a preload only loads the positions. Joints work as
// parallel lanes, each one owning its position and stored rate; the merge
// stage adds the gripper and holds the result in the response register, so
// a new request is taken while a finished result still waits. Mode priority
// per tick, lowest first: rate load, home, zero, then the per-joint zero
// mask; decisions use positions from before the tick. No clearing pass:
// control state, positions, rates, gripper and settings are set by reset.
// ----------------------------------------------------------------------------
module joint_setpoint_integrator_homing import jsih_pkg::*; #(
   parameter int NUM_JOINTS = NUM_JOINTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   jsih_req_if.sink              req_bus,
   jsih_rsp_if.source            rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

`include "assert_macros.svh"

   state_type state_ff, state_in;
   cfg_type   cfg_ff;
   logic [POS_W-1:0] step_ff;     // max_rate * T, rounded; re-registered from the current settings

   // latched request
   logic                    kind_ff, rate_load_ff, home_ff, zero_ff;
   logic [NFIELD-1:0]       mask_ff;
   logic signed [POS_W-1:0] value_ff [NFIELD];
   logic signed [POS_W-1:0] grate_ff;

   logic signed [POS_W-1:0] lane_pos [NUM_JOINTS];
   logic [NUM_JOINTS-1:0]   lanes_busy;
   logic                    out_free, start, finish, accept;
   logic [TP_W+MR_W:0]      step_sum;

   assign accept = req_bus.valid && req_bus.ready;
   assign start  = state_ff == ST_START;

   always_comb begin
      state_in      = state_ff;
      req_bus.ready = 1'b0;
      finish        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) state_in = ST_START;
         end
         ST_START: state_in = ST_BUSY;
         ST_BUSY: begin
            // lanes done and response register free: load it
            if (lanes_busy == '0 && out_free) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign step_sum = (TP_W + MR_W + 1)'(cfg_ff.max_rate * cfg_ff.sample_period)
                   + (TP_W + MR_W + 1)'(1 << (TP_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= ST_IDLE;
         cfg_ff.sample_period <= PERIOD_RESET;
         cfg_ff.max_rate      <= MAX_RATE_RESET;
         cfg_ff.deadband      <= DEADBAND_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_PERIOD:   cfg_ff.sample_period <= csr_data[TP_W-1:0];
               CSR_MAX_RATE: cfg_ff.max_rate      <= csr_data[MR_W-1:0];
               CSR_DEADBAND: cfg_ff.deadband      <= csr_data[DB_W-1:0];
               default: ;    // unmapped index: write dropped
            endcase
         end
      end
      step_ff <= POS_W'(step_sum >> TP_W);
      if (accept) begin
         kind_ff      <= req_bus.kind;
         rate_load_ff <= req_bus.rate_load;
         home_ff      <= req_bus.home_request;
         zero_ff      <= req_bus.zero_request;
         mask_ff      <= req_bus.joint_zero_mask;
         grate_ff     <= req_bus.gripper_rate;
         value_ff[0]  <= req_bus.value_0;
         value_ff[1]  <= req_bus.value_1;
         value_ff[2]  <= req_bus.value_2;
         value_ff[3]  <= req_bus.value_3;
         value_ff[4]  <= req_bus.value_4;
         value_ff[5]  <= req_bus.value_5;
      end
   end

   // joint lanes; lane j watches lane j+1 for the homing and zeroing sequences
   for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_lane
      lane_cmd_type            cmd;
      logic signed [POS_W-1:0] nxt;

      assign cmd.kind      = kind_ff;
      assign cmd.rate_load = rate_load_ff;
      assign cmd.home      = home_ff;
      assign cmd.zero      = zero_ff;
      if (j < NFIELD) begin : g_field
         assign cmd.mask_bit = mask_ff[j];
         assign cmd.value    = value_ff[j];
      end else begin : g_nofield
         assign cmd.mask_bit = 1'b0;
         assign cmd.value    = '0;
      end
      if (j == NUM_JOINTS - 1) begin : g_last
         assign nxt = lane_pos[j];
      end else begin : g_mid
         assign nxt = lane_pos[j + 1];
      end

      jsih_lane #(
         .JOINT (j),
         .LAST  (j == NUM_JOINTS - 1)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .start    (start),
         .cmd      (cmd),
         .cfg      (cfg_ff),
         .step     (step_ff),
         .next_pos (nxt),
         .pos      (lane_pos[j]),
         .busy     (lanes_busy[j])
      );
   end

   jsih_merge #(
      .NUM_JOINTS (NUM_JOINTS)
   ) u_merge (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .kind          (kind_ff),
      .gripper_rate  (grate_ff),
      .sample_period (cfg_ff.sample_period),
      .finish        (finish),
      .lane_pos      (lane_pos),
      .out_free      (out_free),
      .rsp_bus       (rsp_bus)
   );

   `ASSERT_NEXT(a_accept_starts, accept, state_ff == ST_START, "accepted item did not start lanes")
   `ASSERT_NEXT(a_finish_shows, finish, rsp_bus.valid, "finished item not presented")
   `ASSERT_IMPL(a_grip_range, rsp_bus.valid, rsp_bus.gripper_pos <= GRIP_ONE, "gripper above 1.0")
   `ASSERT_IMPL(a_busy_blocks, lanes_busy != '0, !req_bus.ready, "request taken while lanes run")

endmodule

/* bench/tb_joint_setpoint_integrator_homing.sv */
// ----------------------------------------------------------------------------
// tb_joint_setpoint_integrator_homing
// Self-checking bench for the joint setpoint integrator with homing.
// ----------------------------------------------------------------------------
// A queue of request items feeds a bursty driver. Each transfer that the
// block accepts runs through a bit-accurate model of the integrator, and the
// model's position set is queued. The monitor checks every response transfer
// against the oldest queued position set. The run walks through several
// register settings, written only while the block is drained.
// ----------------------------------------------------------------------------
module tb_joint_setpoint_integrator_homing import jsih_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NJ        = 6;
   localparam int CYC_LIMIT = 2000000;
   localparam int SETTLE    = 80;        // longer than one landing tick

   typedef struct {
      bit                      kind;
      bit                      rate_load;
      logic signed [POS_W-1:0] value [NJ];
      logic signed [POS_W-1:0] grip_rate;
      bit                      home;
      bit                      zero;
      logic [NFIELD-1:0]       mask;
   } setpoint_req_type;

   typedef struct {
      logic signed [POS_W-1:0] pos [NJ];
      logic [GRIP_W-1:0]       grip;
   } setpoint_rsp_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   jsih_req_if req_bus ();
   jsih_rsp_if rsp_bus ();

   joint_setpoint_integrator_homing u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // ------------------------------------------------------------------------
   // model state and register copies
   // ------------------------------------------------------------------------
   longint q_pos [NJ];
   longint q_rate [NJ];
   longint grip_q;
   longint t_period;
   longint rate_cap;
   longint arrive_tol;

   // homing targets at 16 fraction bits (half away from zero)
   const longint HOME_POS [NJ] = '{0, 28595, 97225, 0, -34315, 0};

   setpoint_req_type pending_reqs [$];
   setpoint_rsp_type expected_pos [$];
   int               errors;
   int               cycles;

   function automatic longint sat24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   // rate * T, round half up
   function automatic longint rate_times_t(longint r);
      return (r * t_period + 64'sd32768) >>> 16;
   endfunction

   // (d / T), round half away from zero, so that the landing step is exact
   function automatic longint landing_rate(longint d);
      longint t;
      longint num;
      longint mag;
      longint qt;
      t   = (t_period != 0) ? t_period : 1;
      num = d * 64'sd65536;
      mag = (num < 0) ? -num : num;
      qt  = (mag + t / 2) / t;
      return sat24((num < 0) ? -qt : qt);
   endfunction

   function automatic longint approach_rate(longint q, longint tgt);
      longint step;
      step = rate_times_t(rate_cap);
      if (q < tgt - arrive_tol)
         return (q + step <= tgt) ? rate_cap : landing_rate(tgt - q);
      if (q > tgt + arrive_tol)
         return (q - step >= tgt) ? -rate_cap : landing_rate(tgt - q);
      return 0;
   endfunction

   // last joint first; joint i moves once joint i+1 sits within the deadband
   task automatic run_sequence(bit to_home);
      longint tg [NJ];
      longint e;
      for (int i = 0; i < NJ; i++) tg[i] = to_home ? HOME_POS[i] : 0;
      q_rate[NJ-1] = approach_rate(q_pos[NJ-1], tg[NJ-1]);
      for (int i = NJ - 2; i >= 0; i--) begin
         e = q_pos[i+1] - tg[i+1];
         if (e <= arrive_tol && e >= -arrive_tol)
            q_rate[i] = approach_rate(q_pos[i], tg[i]);
         else
            q_rate[i] = 0;
      end
   endtask

   task automatic predict_setpoint(input setpoint_req_type it);
      setpoint_rsp_type r;
      longint           g;
      if (it.kind) begin
         for (int j = 0; j < NJ; j++) q_pos[j] = it.value[j];
      end else begin
         if (it.rate_load)
            for (int j = 0; j < NJ; j++) q_rate[j] = it.value[j];
         if (it.home) run_sequence(1'b1);
         if (it.zero) run_sequence(1'b0);
         for (int j = 0; j < NJ; j++)
            if (it.mask[j]) q_rate[j] = approach_rate(q_pos[j], 0);
         for (int j = 0; j < NJ; j++)
            q_pos[j] = sat24(q_pos[j] + rate_times_t(q_rate[j]));
         g = grip_q + rate_times_t(longint'(it.grip_rate));
         if (g <= 0) g = 0;
         else if (g >= 65536) g = 65536;
         grip_q = g;
      end
      for (int j = 0; j < NJ; j++) r.pos[j] = q_pos[j][POS_W-1:0];
      r.grip = grip_q[GRIP_W-1:0];
      expected_pos.push_back(r);
   endtask

   // ------------------------------------------------------------------------
   // clock
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // driver: bursts of transfers separated by random gaps
   // ------------------------------------------------------------------------
   setpoint_req_type in_flight;
   int               burst_left;
   int               gap_left;

   always @(posedge clock) begin
      setpoint_req_type nx;
      bit               accept;
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left    <= 0;
         gap_left      <= 0;
      end else begin
         accept = req_bus.valid && req_bus.ready;
         if (accept) predict_setpoint(in_flight);
         if (!req_bus.valid || accept) begin
            if (gap_left > 0) begin
               gap_left      <= gap_left - 1;
               req_bus.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               nx        = pending_reqs.pop_front();
               in_flight = nx;
               req_bus.valid           <= 1'b1;
               req_bus.kind            <= nx.kind;
               req_bus.rate_load       <= nx.rate_load;
               req_bus.value_0         <= nx.value[0];
               req_bus.value_1         <= nx.value[1];
               req_bus.value_2         <= nx.value[2];
               req_bus.value_3         <= nx.value[3];
               req_bus.value_4         <= nx.value[4];
               req_bus.value_5         <= nx.value[5];
               req_bus.gripper_rate    <= nx.grip_rate;
               req_bus.home_request    <= nx.home;
               req_bus.zero_request    <= nx.zero;
               req_bus.joint_zero_mask <= nx.mask;
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 24);
                  // about a third of bursts end with no gap at all
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver: one of four ready stall styles, re-drawn at random by a counter of cycles
   // ------------------------------------------------------------------------
   int stall_style;
   int stall_ctr;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_style   <= 0;
         stall_ctr     <= 0;
      end else begin
         stall_ctr <= stall_ctr + 1;
         if (stall_ctr % 300 == 299) stall_style <= $urandom_range(0, 3);
         case (stall_style)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= ($urandom_range(0, 1) == 1);
            2:       rsp_bus.ready <= (stall_ctr % 7) < 2;
            default: rsp_bus.ready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // monitor: check each response transfer against the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      setpoint_rsp_type act;
      setpoint_rsp_type exp_r;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         act.pos[0] = rsp_bus.pos_0;
         act.pos[1] = rsp_bus.pos_1;
         act.pos[2] = rsp_bus.pos_2;
         act.pos[3] = rsp_bus.pos_3;
         act.pos[4] = rsp_bus.pos_4;
         act.pos[5] = rsp_bus.pos_5;
         act.grip   = rsp_bus.gripper_pos;
         if (expected_pos.size() == 0) begin
            errors++;
            $display("%0t: response transfer with nothing expected (pos_0 %0d)",
                     $time, act.pos[0]);
         end else begin
            exp_r = expected_pos.pop_front();
            for (int j = 0; j < NJ; j++)
               if (act.pos[j] !== exp_r.pos[j]) begin
                  errors++;
                  $display("%0t: pos_%0d expected %0d actual %0d",
                           $time, j, exp_r.pos[j], act.pos[j]);
               end
            if (act.grip !== exp_r.grip) begin
               errors++;
               $display("%0t: gripper_pos expected %0d actual %0d",
                        $time, exp_r.grip, act.grip);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYC_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic setpoint_req_type blank_tick();
      setpoint_req_type it;
      it.kind      = 1'b0;
      it.rate_load = 1'b0;
      for (int j = 0; j < NJ; j++) it.value[j] = '0;
      it.grip_rate = '0;
      it.home      = 1'b0;
      it.zero      = 1'b0;
      it.mask      = '0;
      return it;
   endfunction

   // fully random item: every field bit toggles
   function automatic setpoint_req_type noise_item();
      setpoint_req_type it;
      it.kind      = ($urandom_range(0, 3) == 0);
      it.rate_load = 1'($urandom_range(0, 1));
      for (int j = 0; j < NJ; j++) it.value[j] = POS_W'($urandom);
      it.grip_rate = POS_W'($urandom);
      it.home      = ($urandom_range(0, 3) == 0);
      it.zero      = ($urandom_range(0, 3) == 0);
      it.mask      = ($urandom_range(0, 1) == 1) ? NFIELD'($urandom) : '0;
      return it;
   endfunction

   // preload near the targets, then a run of homing or zeroing ticks
   task automatic queue_approach_run();
      setpoint_req_type it;
      bit               to_home;
      int               n;
      it = blank_tick();
      it.kind = 1'b1;
      for (int j = 0; j < NJ; j++)
         it.value[j] = POS_W'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      pending_reqs.push_back(it);
      to_home = 1'($urandom_range(0, 1));
      n       = $urandom_range(15, 60);
      for (int k = 0; k < n; k++) begin
         it = blank_tick();
         it.home      = to_home || ($urandom_range(0, 15) == 0);
         it.zero      = !to_home || ($urandom_range(0, 15) == 0);
         it.grip_rate = POS_W'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
         if ($urandom_range(0, 9) == 0) it.mask = NFIELD'($urandom);
         if ($urandom_range(0, 19) == 0) begin
            it.rate_load = 1'b1;
            for (int j = 0; j < NJ; j++) it.value[j] = POS_W'($urandom);
         end
         pending_reqs.push_back(it);
      end
   endtask

   // free rate integration with occasional rate loads and masks
   task automatic queue_rate_run();
      setpoint_req_type it;
      int               n;
      n = $urandom_range(5, 30);
      for (int k = 0; k < n; k++) begin
         it = blank_tick();
         it.rate_load = ($urandom_range(0, 3) == 0);
         for (int j = 0; j < NJ; j++) it.value[j] = POS_W'($urandom);
         it.grip_rate = POS_W'($urandom);
         if ($urandom_range(0, 4) == 0) it.mask = NFIELD'($urandom);
         pending_reqs.push_back(it);
      end
   endtask

   task automatic queue_random(int target);
      int start;
      start = pending_reqs.size();
      while (pending_reqs.size() - start < target)
         case ($urandom_range(0, 9))
            0, 1:    pending_reqs.push_back(noise_item());
            2, 3:    queue_rate_run();
            default: queue_approach_run();
         endcase
   endtask

   task automatic queue_directed();
      setpoint_req_type it;
      // preload both extremes
      it = blank_tick();
      it.kind = 1'b1;
      for (int j = 0; j < NJ; j++) it.value[j] = (j % 2) ? 24'sh7FFFFF : 24'sh800000;
      pending_reqs.push_back(it);
      // extreme rates: positions saturate, gripper clamps high then low
      it = blank_tick();
      it.rate_load = 1'b1;
      for (int j = 0; j < NJ; j++) it.value[j] = (j % 2) ? 24'sh7FFFFF : 24'sh800000;
      it.grip_rate = 24'sh7FFFFF;
      repeat (3) pending_reqs.push_back(it);
      it = blank_tick();
      it.rate_load = 1'b1;
      for (int j = 0; j < NJ; j++) it.value[j] = (j % 2) ? 24'sh800000 : 24'sh7FFFFF;
      it.grip_rate = 24'sh800000;
      repeat (3) pending_reqs.push_back(it);
      // preload off-target, then homing ticks with the landing step
      it = blank_tick();
      it.kind = 1'b1;
      for (int j = 0; j < NJ; j++) it.value[j] = POS_W'(700 * (j + 1));
      it.value[4] = -24'sd1000;
      pending_reqs.push_back(it);
      it = blank_tick();
      it.home = 1'b1;
      repeat (5) pending_reqs.push_back(it);
      // home and zero together: zero wins
      it.zero = 1'b1;
      repeat (2) pending_reqs.push_back(it);
      // per-joint zero on every joint, on both sides of zero, overriding home
      it = blank_tick();
      it.kind = 1'b1;
      for (int j = 0; j < NJ; j++) it.value[j] = (j % 2) ? 24'sd900 : -24'sd900;
      pending_reqs.push_back(it);
      it = blank_tick();
      it.home = 1'b1;
      it.mask = 6'h3F;
      repeat (3) pending_reqs.push_back(it);
      // preload ignores rates and gripper
      it = noise_item();
      it.kind = 1'b1;
      pending_reqs.push_back(it);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, longint unsigned val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(val);
      case (idx)
         CSR_PERIOD:   t_period   = val & 16'hFFFF;
         CSR_MAX_RATE: rate_cap   = val & 23'h7FFFFF;
         default:      arrive_tol = val & 16'hFFFF;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_regs(longint unsigned per, longint unsigned mr, longint unsigned db);
      write_reg(CSR_PERIOD, per);
      write_reg(CSR_MAX_RATE, mr);
      write_reg(CSR_DEADBAND, db);
   endtask

   // drained: nothing queued, nothing on the bus, nothing outstanding
   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_bus.valid || expected_pos.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      errors = 0;
      cycles = 0;
      for (int j = 0; j < NJ; j++) begin
         q_pos[j]  = 0;
         q_rate[j] = 0;
      end
      grip_q     = 32768;
      t_period   = PERIOD_RESET;
      rate_cap   = MAX_RATE_RESET;
      arrive_tol = DEADBAND_RESET;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      req_bus.valid           = 1'b0;
      req_bus.kind            = 1'b0;
      req_bus.rate_load       = 1'b0;
      req_bus.value_0         = '0;
      req_bus.value_1         = '0;
      req_bus.value_2         = '0;
      req_bus.value_3         = '0;
      req_bus.value_4         = '0;
      req_bus.value_5         = '0;
      req_bus.gripper_rate    = '0;
      req_bus.home_request    = 1'b0;
      req_bus.zero_request    = 1'b0;
      req_bus.joint_zero_mask = '0;
      rsp_bus.ready           = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings
      queue_directed();
      queue_random(300);
      wait_drained();

      // long period, fastest rate, no deadband
      set_regs(65535, 8388607, 0);
      queue_directed();
      queue_random(300);
      wait_drained();

      // shortest period, no approach motion, widest deadband
      set_regs(1, 0, 65535);
      queue_random(200);
      wait_drained();

      // brisk homing: 0.2 s ticks, 2.0 rad/s
      set_regs(13107, 131072, 66);
      queue_random(350);
      wait_drained();

      set_regs(6554, 65536, 0);
      queue_random(350);
      wait_drained();

      set_regs($urandom_range(1, 65535), $urandom_range(0, 1 << 19), $urandom_range(0, 2000));
      queue_random(350);
      wait_drained();

      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
